/* design/urc_pkg.sv */
package urc_pkg;

  localparam int unsigned PhaseW  = 3;
  localparam int unsigned TicksW  = 20;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned FracW   = 6;
  localparam int unsigned DistW   = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 20;

  localparam logic [PhaseW-1:0] PH_TRIG_LOW  = 3'd0;
  localparam logic [PhaseW-1:0] PH_TRIG_HIGH = 3'd1;
  localparam logic [PhaseW-1:0] PH_WAIT_RISE = 3'd2;
  localparam logic [PhaseW-1:0] PH_COUNT     = 3'd3;
  localparam logic [PhaseW-1:0] PH_IDLE      = 3'd4;

  localparam logic [TicksW-1:0] TRIG_LOW_TICKS  = 20'd2;
  localparam logic [TicksW-1:0] TRIG_HIGH_TICKS = 20'd10;
  localparam logic [FracW-1:0]  US_PER_CM       = 6'd58;
  localparam logic [DistW-1:0]  CM_COUNT_MAX    = 11'd1129;

  localparam logic [CfgIdxW-1:0] REG_STOP_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STOP_ENABLE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RISE_TIMEOUT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ECHO_TIMEOUT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IDLE_GAP       = 3'd4;

  localparam logic [DistW-1:0]  RST_STOP_THRESHOLD = 11'd15;
  localparam logic [WidthW-1:0] RST_RISE_TIMEOUT   = 16'd5000;
  localparam logic [WidthW-1:0] RST_ECHO_TIMEOUT   = 16'd30000;
  localparam logic [TicksW-1:0] RST_IDLE_GAP       = 20'd30000;

  typedef struct packed {
    logic [DistW-1:0]  stop_threshold_cm;
    logic              stop_enable;
    logic [WidthW-1:0] rise_timeout_us;
    logic [WidthW-1:0] echo_timeout_us;
    logic [TicksW-1:0] idle_gap_us;
  } cfg_t;

  typedef struct packed {
    logic             trigger_level;
    logic [DistW-1:0] distance_cm;
    logic             distance_done;
    logic             stop_request;
  } res_t;

endpackage

/* design/urc_core.sv */
module urc_core import urc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic echo_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic [WidthW-1:0] width_q, width_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [DistW-1:0]  cm_q, cm_d;
  logic [DistW-1:0]  last_q, last_d;

  always_comb begin
    logic              store;
    logic [DistW-1:0]  store_cm;
    logic [TicksW-1:0] low_cnt;
    logic [TicksW-1:0] ticks_inc;
    logic [WidthW-1:0] width_inc;
    logic [FracW-1:0]  frac_inc;

    phase_d   = phase_q;
    ticks_d   = ticks_q;
    width_d   = width_q;
    frac_d    = frac_q;
    cm_d      = cm_q;
    last_d    = last_q;
    store     = 1'b0;
    store_cm  = '0;
    ticks_inc = ticks_q + 20'd1;
    width_inc = width_q + 16'd1;
    frac_inc  = frac_q + 6'd1;
    low_cnt   = '0;
    res_o     = '0;

    unique case (phase_q)
      PH_TRIG_HIGH: begin
        res_o.trigger_level = 1'b1;
        ticks_d = ticks_inc;
        if (ticks_inc >= TRIG_HIGH_TICKS) begin
          ticks_d = '0;
          phase_d = PH_WAIT_RISE;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_i) begin
          width_d = 16'd1;
          frac_d  = 6'd1;
          cm_d    = '0;
          ticks_d = '0;
          phase_d = PH_COUNT;
        end else begin
          ticks_d = ticks_inc;
          if (ticks_inc >= TicksW'(cfg_i.rise_timeout_us)) begin
            store = 1'b1;
          end
        end
      end
      PH_COUNT: begin
        if (!echo_i) begin
          store    = 1'b1;
          store_cm = cm_q + 11'd1;
        end else if (width_q >= cfg_i.echo_timeout_us) begin
          store = 1'b1;
        end else begin
          width_d = width_inc;
          frac_d  = frac_inc;
          // carry one cm per 58 us, saturate the count
          if (frac_inc >= US_PER_CM) begin
            frac_d = '0;
            if (cm_q < CM_COUNT_MAX) begin
              cm_d = cm_q + 11'd1;
            end
          end
          if (width_inc >= cfg_i.echo_timeout_us) begin
            store = 1'b1;
          end
        end
      end
      PH_IDLE: begin
        ticks_d = ticks_inc;
        if (ticks_inc >= cfg_i.idle_gap_us) begin
          ticks_d = '0;
          phase_d = PH_TRIG_LOW;
        end
      end
      default: begin
        // counts the trigger-low phase; unused codes restart the trigger-low phase
        low_cnt = ((phase_q == PH_TRIG_LOW) ? ticks_q : '0) + 20'd1;
        phase_d = PH_TRIG_LOW;
        ticks_d = low_cnt;
        if (low_cnt >= TRIG_LOW_TICKS) begin
          ticks_d = '0;
          phase_d = PH_TRIG_HIGH;
        end
      end
    endcase

    if (store) begin
      last_d  = store_cm;
      ticks_d = '0;
      phase_d = (cfg_i.idle_gap_us == '0) ? PH_TRIG_LOW : PH_IDLE;
      res_o.distance_done = 1'b1;
      res_o.stop_request  = cfg_i.stop_enable && (store_cm != '0) &&
                            (store_cm < cfg_i.stop_threshold_cm);
    end
    res_o.distance_cm = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TRIG_LOW;
      ticks_q <= '0;
      width_q <= '0;
      frac_q  <= '0;
      cm_q    <= '0;
      last_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      width_q <= width_d;
      frac_q  <= frac_d;
      cm_q    <= cm_d;
      last_q  <= last_d;
    end
  end

endmodule

/* design/ultrasonic_range_controller.sv */
// Ultrasonic ranging controller for an HC-SR04 style sensor.
// Input channel: one item per microsecond tick, carrying the sampled echo
// level (echo_level_i) under in_valid_i / in_ready_o.
// Output channel: exactly one item per input item: trigger pin level,
// last stored distance in cm, a done flag on the tick a distance is stored
// and a stop request on that tick (when enabled and the distance is nonzero
// and below the threshold). Handshake is out_valid_o / out_ready_i.
// Latency: the result of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle; the sequencer and the result register
// take a new tick while the previous result is being taken.
// A stall on the output holds the result register and drops in_ready_o;
// the sequencer then holds too, so no tick is lost.
// Configuration: cfg_we_i with cfg_idx_i / cfg_wdata_i writes one register
// in a cycle; indexes beyond the last register are ignored.
// Reset: registers return to their defaults (threshold 15, stop disabled,
// rise timeout 5000, echo timeout 30000, idle gap 30000), the sequencer
// restarts in the trigger-low phase and the stored distance is zero.
module ultrasonic_range_controller import urc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               echo_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               trigger_level_o,
  output logic [DistW-1:0]   distance_cm_o,
  output logic               distance_done_o,
  output logic               stop_request_o
);

  cfg_t cfg_q;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_threshold_cm <= RST_STOP_THRESHOLD;
      cfg_q.stop_enable       <= 1'b0;
      cfg_q.rise_timeout_us   <= RST_RISE_TIMEOUT;
      cfg_q.echo_timeout_us   <= RST_ECHO_TIMEOUT;
      cfg_q.idle_gap_us       <= RST_IDLE_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STOP_THRESHOLD: cfg_q.stop_threshold_cm <= cfg_wdata_i[DistW-1:0];
        REG_STOP_ENABLE:    cfg_q.stop_enable       <= cfg_wdata_i[0];
        REG_RISE_TIMEOUT:   cfg_q.rise_timeout_us   <= cfg_wdata_i[WidthW-1:0];
        REG_ECHO_TIMEOUT:   cfg_q.echo_timeout_us   <= cfg_wdata_i[WidthW-1:0];
        REG_IDLE_GAP:       cfg_q.idle_gap_us       <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;

  urc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .echo_i    (echo_level_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // hold the payload until the item is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = res_q.trigger_level;
  assign distance_cm_o   = res_q.distance_cm;
  assign distance_done_o = res_q.distance_done;
  assign stop_request_o  = res_q.stop_request;

  a_stop_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_request_o |-> distance_done_o && (distance_cm_o != '0))
    else $error("stop request without a nonzero stored distance");

  a_trig_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(trigger_level_o && distance_done_o))
    else $error("trigger high on a done tick");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_stop_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cfg_q.stop_enable |=> !stop_request_o)
    else $error("stop request while stopping is disabled");

endmodule
